### hdl/ttip_pkg.sv
// Shared types and constants for the streaming text to integer parser.
// Used by the front classifier, the queue, the back end and the top level.
package ttip_pkg;

    localparam int BASE_BITS  = 6;
    localparam int DIGIT_BITS = 6;
    localparam int OFFSET_BITS = 16;

    localparam logic [BASE_BITS-1:0] BASE_DETECT = 6'd0;
    localparam logic [BASE_BITS-1:0] BASE_MIN    = 6'd2;
    localparam logic [BASE_BITS-1:0] BASE_OCT    = 6'd8;
    localparam logic [BASE_BITS-1:0] BASE_DEC    = 6'd10;
    localparam logic [BASE_BITS-1:0] BASE_HEX    = 6'd16;
    localparam logic [BASE_BITS-1:0] BASE_MAX    = 6'd36;
    localparam logic [BASE_BITS-1:0] BASE_RESET  = BASE_DEC;

    // Digit code of a character that is no digit in any base.
    localparam logic [DIGIT_BITS-1:0] DIGIT_NONE = 6'd63;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_UPPER_X = 8'h58;
    localparam logic [7:0] CH_LOWER_X = 8'h78;

    typedef struct packed {
        logic                  is_space;
        logic                  is_sign;
        logic                  is_minus;
        logic                  is_zero;
        logic                  is_x;
        logic [DIGIT_BITS-1:0] digit;
    } t_char_class;

    typedef struct packed {
        logic busy;
        logic pop;
    } t_back_status;

endpackage

### hdl/text_to_integer_parser.sv
// A terminating character's result is registered as the back end takes it from the queue;
// the back end takes it once any digits queued ahead of it are accumulated and the output
// register is free, so an output stall holds it back.
// Space, sign and prefix characters are taken from the queue head without a pause; a digit
// is taken with the multiply, then the back end is busy for the add-and-limit-compare on the accumulator.
// Reset is synchronous and active low; it empties the parser and sets base to 10.
module text_to_integer_parser #(
    parameter int VALUE_BITS = 64,
    parameter int COUNT_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [ttip_pkg::BASE_BITS-1:0]   i_cfg_wr_data,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [7:0]                       i_char_in,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic signed [63:0]               o_value,
    output logic [ttip_pkg::OFFSET_BITS-1:0] o_end_offset,
    output logic                             o_digits_found,
    output logic                             o_overflow
);
    import ttip_pkg::*;

    logic [BASE_BITS-1:0]         r_base;
    logic                         fifo_full;
    logic                         fifo_push;
    logic                         fifo_valid;
    logic                         fifo_pop;
    t_char_class                  front_class;
    t_char_class                  head_class;
    t_back_status                 back_status;
    logic signed [VALUE_BITS-1:0] back_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= BASE_RESET;
        end else if (i_cfg_wr_en) begin
            r_base <= i_cfg_wr_data;
        end
    end

    ttip_front u_front (
        .i_valid   (i_valid),
        .i_char_in (i_char_in),
        .i_full    (fifo_full),
        .o_stall   (o_stall),
        .o_push    (fifo_push),
        .o_class   (front_class)
    );

    ttip_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fifo_push),
        .i_data  (front_class),
        .i_pop   (fifo_pop),
        .o_full  (fifo_full),
        .o_valid (fifo_valid),
        .o_data  (head_class)
    );

    ttip_back #(
        .VALUE_BITS (VALUE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_base         (r_base),
        .i_head_valid   (fifo_valid),
        .i_head         (head_class),
        .o_pop          (fifo_pop),
        .o_status       (back_status),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_value        (back_value),
        .o_end_offset   (o_end_offset),
        .o_digits_found (o_digits_found),
        .o_overflow     (o_overflow)
    );

    // Sign-extend the internal value to the 64-bit port.
    assign o_value = 64'(back_value);

`ifndef SYNTH
    a_no_pop_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_status.busy |-> !back_status.pop)
        else $error("queue popped during digit accumulation");

    a_overflow_has_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_overflow || o_digits_found))
        else $error("overflow reported without digits");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_digits_found) |-> (o_value == 64'sd0 && o_end_offset == '0))
        else $error("result without digits is not zero");

    a_saturated_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overflow) |->
            (o_value == 64'($signed({1'b0, {(VALUE_BITS-1){1'b1}}})) ||
             o_value == 64'($signed({1'b1, {(VALUE_BITS-1){1'b0}}}))))
        else $error("overflowed value is not at a signed limit");
`endif

endmodule

### hdl/ttip_front.sv
// Front end of the parser: classifies each incoming character.
// Depends on ttip_pkg; pushes classified characters into ttip_fifo.
module ttip_front (
    input  logic               i_valid,
    input  logic [7:0]         i_char_in,
    input  logic               i_full,
    output logic               o_stall,
    output logic               o_push,
    output ttip_pkg::t_char_class o_class
);
    import ttip_pkg::*;

    logic [7:0] digit_wide;

    always_comb begin
        if (i_char_in >= CH_ZERO && i_char_in <= CH_NINE) begin
            digit_wide = i_char_in - CH_ZERO;
        end else if (i_char_in >= CH_UPPER_A && i_char_in <= CH_UPPER_Z) begin
            digit_wide = i_char_in - (CH_UPPER_A - 8'd10);
        end else if (i_char_in >= CH_LOWER_A && i_char_in <= CH_LOWER_Z) begin
            digit_wide = i_char_in - (CH_LOWER_A - 8'd10);
        end else begin
            digit_wide = 8'(DIGIT_NONE);
        end
    end

    assign o_class.is_space = (i_char_in == CH_SPACE);
    assign o_class.is_sign  = (i_char_in == CH_PLUS) || (i_char_in == CH_MINUS);
    assign o_class.is_minus = (i_char_in == CH_MINUS);
    assign o_class.is_zero  = (i_char_in == CH_ZERO);
    assign o_class.is_x     = (i_char_in == CH_UPPER_X) || (i_char_in == CH_LOWER_X);
    assign o_class.digit    = digit_wide[DIGIT_BITS-1:0];

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

endmodule

### hdl/ttip_fifo.sv
// Two-entry queue of classified characters between front and back end.
// Depends on ttip_pkg for the entry type.
module ttip_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  ttip_pkg::t_char_class i_data,
    input  logic                  i_pop,
    output logic                  o_full,
    output logic                  o_valid,
    output ttip_pkg::t_char_class o_data
);
    import ttip_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    t_char_class         r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wptr;
    logic [PTR_BITS-1:0] r_rptr;
    logic [CNT_BITS-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CNT_BITS'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### hdl/ttip_back.sv
// Back end of the parser: prefix and sign handling, digit accumulation with
// overflow detection, and the result register. Depends on ttip_pkg.
module ttip_back #(
    parameter int VALUE_BITS = 64,
    parameter int COUNT_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [ttip_pkg::BASE_BITS-1:0]    i_base,
    input  logic                              i_head_valid,
    input  ttip_pkg::t_char_class             i_head,
    output logic                              o_pop,
    output ttip_pkg::t_back_status            o_status,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [VALUE_BITS-1:0]      o_value,
    output logic [ttip_pkg::OFFSET_BITS-1:0]  o_end_offset,
    output logic                              o_digits_found,
    output logic                              o_overflow
);
    import ttip_pkg::*;

    typedef enum logic [1:0] {PH_SKIP, PH_SIGN, PH_ZERO, PH_DIGITS} t_phase;

    localparam int PROD_BITS = VALUE_BITS + BASE_BITS;
    localparam int SUM_BITS  = PROD_BITS + 1;
    localparam int WIDE_BITS = COUNT_BITS + OFFSET_BITS;
    localparam logic [VALUE_BITS-1:0] HALF = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam logic [VALUE_BITS-1:0] MAXV = ~HALF;

    t_phase                  r_phase,  n_phase;
    logic                    r_neg,    n_neg;
    logic [BASE_BITS-1:0]    r_active, n_active;
    logic [VALUE_BITS-1:0]   r_acc,    n_acc;
    logic                    r_any,    n_any;
    logic                    r_ovf,    n_ovf;
    logic [COUNT_BITS-1:0]   r_pos,    n_pos;
    logic                    r_busy,   n_busy;
    logic [PROD_BITS-1:0]    r_prod,   n_prod;
    logic [DIGIT_BITS-1:0]   r_digit,  n_digit;

    logic                    r_ovalid;
    logic signed [VALUE_BITS-1:0] r_value;
    logic [OFFSET_BITS-1:0]  r_off;
    logic                    r_found;
    logic                    r_oovf;

    logic                    out_free;
    logic                    emit;
    logic                    try_digit;
    logic                    digit_ok;
    logic [BASE_BITS-1:0]    eff_base;
    logic                    eff_any;
    logic [COUNT_BITS-1:0]   pos_inc;
    logic [WIDE_BITS-1:0]    pos_wide;
    logic [OFFSET_BITS-1:0]  pos_sat;
    logic [SUM_BITS-1:0]     sum;
    logic [SUM_BITS-1:0]     limit;
    logic [VALUE_BITS-1:0]   result_value;

    assign out_free = !r_ovalid || !i_stall;
    assign pos_inc  = (&r_pos) ? r_pos : r_pos + 1'b1;
    assign pos_wide = WIDE_BITS'(r_pos);
    assign pos_sat  = (|pos_wide[WIDE_BITS-1:OFFSET_BITS]) ? '1 : pos_wide[OFFSET_BITS-1:0];

    // Second half of a digit: acc*base + digit must not pass the signed limit.
    assign sum   = SUM_BITS'(r_prod) + SUM_BITS'(r_digit);
    assign limit = r_neg ? SUM_BITS'(HALF) : SUM_BITS'(MAXV);

    always_comb begin
        if (r_ovf) begin
            result_value = r_neg ? HALF : MAXV;
        end else begin
            result_value = r_neg ? (VALUE_BITS'(0) - r_acc) : r_acc;
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_neg     = r_neg;
        n_active  = r_active;
        n_acc     = r_acc;
        n_any     = r_any;
        n_ovf     = r_ovf;
        n_pos     = r_pos;
        n_busy    = 1'b0;
        n_prod    = r_prod;
        n_digit   = r_digit;
        o_pop     = 1'b0;
        emit      = 1'b0;
        try_digit = 1'b0;
        digit_ok  = 1'b0;
        eff_base  = r_active;
        eff_any   = r_any;

        if (r_busy) begin
            if (!r_ovf) begin
                if (sum > limit) begin
                    n_ovf = 1'b1;
                end else begin
                    n_acc = sum[VALUE_BITS-1:0];
                end
            end
        end else if (i_head_valid) begin
            unique case (r_phase) inside
                PH_SKIP, PH_SIGN: begin
                    if (r_phase == PH_SKIP && i_head.is_space) begin
                        o_pop = 1'b1;
                        n_pos = pos_inc;
                    end else if (r_phase == PH_SKIP && i_head.is_sign) begin
                        o_pop   = 1'b1;
                        n_neg   = i_head.is_minus;
                        n_phase = PH_SIGN;
                        n_pos   = pos_inc;
                    end else if (i_head.is_zero &&
                                 (i_base == BASE_DETECT || i_base == BASE_HEX)) begin
                        o_pop    = 1'b1;
                        n_active = i_base;
                        n_phase  = PH_ZERO;
                        n_pos    = pos_inc;
                    end else begin
                        eff_base  = (i_base == BASE_DETECT) ? BASE_DEC : i_base;
                        try_digit = 1'b1;
                    end
                end
                PH_ZERO: begin
                    if (i_head.is_x) begin
                        o_pop    = 1'b1;
                        n_active = BASE_HEX;
                        n_phase  = PH_DIGITS;
                        n_pos    = pos_inc;
                    end else begin
                        // The leading zero itself counts as a digit.
                        eff_base  = (r_active == BASE_DETECT) ? BASE_OCT : r_active;
                        eff_any   = 1'b1;
                        try_digit = 1'b1;
                    end
                end
                PH_DIGITS: begin
                    try_digit = 1'b1;
                end
            endcase

            if (try_digit) begin
                digit_ok = (eff_base >= BASE_MIN) && (eff_base <= BASE_MAX) &&
                           (i_head.digit < eff_base);
                if (digit_ok) begin
                    o_pop    = 1'b1;
                    n_active = eff_base;
                    n_any    = 1'b1;
                    n_phase  = PH_DIGITS;
                    n_pos    = pos_inc;
                    n_busy   = 1'b1;
                    n_prod   = PROD_BITS'(r_acc) * PROD_BITS'(eff_base);
                    n_digit  = i_head.digit;
                end else if (out_free) begin
                    o_pop    = 1'b1;
                    emit     = 1'b1;
                    n_phase  = PH_SKIP;
                    n_neg    = 1'b0;
                    n_active = '0;
                    n_acc    = '0;
                    n_any    = 1'b0;
                    n_ovf    = 1'b0;
                    n_pos    = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod  <= n_prod;
        r_digit <= n_digit;
        if (emit) begin
            r_value <= result_value;
            r_off   <= eff_any ? pos_sat : '0;
            r_found <= eff_any;
            r_oovf  <= r_ovf;
        end
        if (!i_rst_n) begin
            r_phase  <= PH_SKIP;
            r_neg    <= 1'b0;
            r_active <= '0;
            r_acc    <= '0;
            r_any    <= 1'b0;
            r_ovf    <= 1'b0;
            r_pos    <= '0;
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_neg    <= n_neg;
            r_active <= n_active;
            r_acc    <= n_acc;
            r_any    <= n_any;
            r_ovf    <= n_ovf;
            r_pos    <= n_pos;
            r_busy   <= n_busy;
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_status.busy  = r_busy;
    assign o_status.pop   = o_pop;
    assign o_valid        = r_ovalid;
    assign o_value        = r_value;
    assign o_end_offset   = r_off;
    assign o_digits_found = r_found;
    assign o_overflow     = r_oovf;

endmodule

### tb/sv/tb_text_to_integer_parser.sv
// Self-checking testbench for text_to_integer_parser: directed rows and random texts, checked
// against a behavioral parser kept in step with the block or, for typed rows, against the table.
// Depends on ttip_pkg and the text_to_integer_parser top level.
module tb_text_to_integer_parser;
    import ttip_pkg::*;

    localparam int          DIRECTED_COUNT = 25;
    localparam int          RANDOM_ITEMS   = 1600;
    localparam int          DRAIN_CYCLES   = 16;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          QUIET_LIMIT    = 4000;
    localparam logic [63:0] SIGN_BIT       = 64'h8000_0000_0000_0000;
    localparam logic [63:0] POS_LIMIT      = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef enum logic [1:0] {PH_SPACES, PH_SIGNED, PH_ZERO, PH_DIGITS} t_parse_phase;

    typedef struct packed {
        logic [63:0] value;
        logic [15:0] end_offset;
        logic        digits_found;
        logic        overflow;
    } t_parse_result;

    typedef struct packed {
        logic                 wr_base;
        logic [BASE_BITS-1:0] base;
        logic [7:0]           ch;
        logic                 typed;
        t_parse_result        exp;
    } t_stim_row;

    localparam t_parse_result NO_NUMBER    = '{64'd0, 16'd0, 1'b0, 1'b0};
    localparam t_parse_result SAT_THIRTEEN = '{POS_LIMIT, 16'd13, 1'b1, 1'b1};

    localparam t_stim_row DIRECTED_ROWS [0:DIRECTED_COUNT-1] = '{
        '{1'b0, 6'd0, "!", 1'b1, NO_NUMBER},
        '{1'b0, 6'd0, CH_MINUS, 1'b0, NO_NUMBER},
        '{1'b0, 6'd0, CH_SPACE, 1'b1, NO_NUMBER},
        '{1'b1, BASE_DETECT, CH_ZERO, 1'b0, NO_NUMBER},
        '{1'b0, 6'd0, CH_LOWER_X, 1'b0, NO_NUMBER},
        '{1'b0, 6'd0, "g", 1'b1, NO_NUMBER},
        '{1'b1, BASE_DETECT, CH_ZERO, 1'b0, NO_NUMBER},
        '{1'b0, 6'd0, "7", 1'b0, NO_NUMBER},
        '{1'b0, 6'd0, 8'hFF, 1'b0, NO_NUMBER},
        '{1'b1, 6'd1, "5", 1'b1, NO_NUMBER},
        '{1'b1, 6'd63, 8'h00, 1'b1, NO_NUMBER},
        '{1'b1, BASE_MAX, CH_LOWER_Z, 1'b0, NO_NUMBER},
        '{1'b0, 6'd0, CH_LOWER_Z, 1'b0, NO_NUMBER},
        '{1'b0, 6'd0, CH_LOWER_Z, 1'b0, NO_NUMBER},
        '{1'b0, 6'd0, CH_LOWER_Z, 1'b0, NO_NUMBER},
        '{1'b0, 6'd0, CH_LOWER_Z, 1'b0, NO_NUMBER},
        '{1'b0, 6'd0, CH_LOWER_Z, 1'b0, NO_NUMBER},
        '{1'b0, 6'd0, CH_LOWER_Z, 1'b0, NO_NUMBER},
        '{1'b0, 6'd0, CH_LOWER_Z, 1'b0, NO_NUMBER},
        '{1'b0, 6'd0, CH_LOWER_Z, 1'b0, NO_NUMBER},
        '{1'b0, 6'd0, CH_LOWER_Z, 1'b0, NO_NUMBER},
        '{1'b0, 6'd0, CH_LOWER_Z, 1'b0, NO_NUMBER},
        '{1'b0, 6'd0, CH_LOWER_Z, 1'b0, NO_NUMBER},
        '{1'b0, 6'd0, CH_LOWER_Z, 1'b0, NO_NUMBER},
        '{1'b0, 6'd0, ".", 1'b1, SAT_THIRTEEN}
    };

    logic                   clk;
    logic                   rst_n       = 1'b0;
    logic                   cfg_wr_en   = 1'b0;
    logic [BASE_BITS-1:0]   cfg_wr_data = '0;
    logic                   in_valid    = 1'b0;
    logic                   in_stall;
    logic [7:0]             in_char     = '0;
    logic                   out_valid;
    logic                   out_stall   = 1'b0;
    logic signed [63:0]     out_value;
    logic [OFFSET_BITS-1:0] out_end_offset;
    logic                   out_digits_found;
    logic                   out_overflow;

    // Behavioral parser state.
    logic [BASE_BITS-1:0]   base_reg;
    t_parse_phase           cur_phase;
    logic                   is_negative;
    logic [BASE_BITS-1:0]   latched_base;
    logic [63:0]            magnitude;
    logic                   have_digit;
    logic                   saturated;
    logic [15:0]            consumed;

    t_parse_result          expected_numbers [$];
    int                     error_count  = 0;
    int                     chars_sent   = 0;
    int                     quiet_cycles = 0;
    int                     hold_left    = 0;
    bit                     no_idle      = 1'b0;
    bit                     hold_req     = 1'b0;
    bit                     hold_started = 1'b0;

    text_to_integer_parser uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .i_valid        (in_valid),
        .o_stall        (in_stall),
        .i_char_in      (in_char),
        .o_valid        (out_valid),
        .i_stall        (out_stall),
        .o_value        (out_value),
        .o_end_offset   (out_end_offset),
        .o_digits_found (out_digits_found),
        .o_overflow     (out_overflow)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [7:0] digit_code(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return c - CH_ZERO;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) return c - CH_UPPER_A + 8'd10;
        if (c >= CH_LOWER_A && c <= CH_LOWER_Z) return c - CH_LOWER_A + 8'd10;
        return {2'b00, DIGIT_NONE};
    endfunction

    function automatic void bump_consumed();
        if (consumed != 16'hFFFF) consumed = consumed + 16'd1;
    endfunction

    function automatic void clear_parse_state();
        cur_phase    = PH_SPACES;
        is_negative  = 1'b0;
        latched_base = '0;
        magnitude    = '0;
        have_digit   = 1'b0;
        saturated    = 1'b0;
        consumed     = '0;
    endfunction

    // Either takes c as a digit of the latched base or closes the number with it.
    function automatic bit digit_or_end(input logic [7:0] c, output t_parse_result r);
        logic [63:0] radix;
        logic [63:0] dval;
        logic [63:0] lim;
        logic [63:0] cutoff;
        logic [63:0] cutlim;
        radix = {58'd0, latched_base};
        dval  = {56'd0, digit_code(c)};
        r     = '0;
        if (radix >= 64'd2 && radix <= 64'd36 && dval < radix) begin
            lim    = is_negative ? SIGN_BIT : POS_LIMIT;
            cutoff = lim / radix;
            cutlim = lim % radix;
            if (saturated || magnitude > cutoff || (magnitude == cutoff && dval > cutlim))
                saturated = 1'b1;
            else
                magnitude = magnitude * radix + dval;
            have_digit = 1'b1;
            cur_phase  = PH_DIGITS;
            bump_consumed();
            return 1'b0;
        end
        if (saturated)
            r.value = is_negative ? SIGN_BIT : POS_LIMIT;
        else
            r.value = is_negative ? 64'd0 - magnitude : magnitude;
        r.end_offset   = have_digit ? consumed : 16'd0;
        r.digits_found = have_digit;
        r.overflow     = saturated;
        clear_parse_state();
        return 1'b1;
    endfunction

    function automatic bit parse_step(input logic [7:0] c, output t_parse_result r);
        r = '0;
        if (cur_phase == PH_SPACES) begin
            if (c == CH_SPACE) begin
                bump_consumed();
                return 1'b0;
            end
            if (c == CH_MINUS || c == CH_PLUS) begin
                is_negative = (c == CH_MINUS);
                cur_phase   = PH_SIGNED;
                bump_consumed();
                return 1'b0;
            end
        end
        if (cur_phase == PH_SPACES || cur_phase == PH_SIGNED) begin
            // The base register is sampled here; a detected base is resolved after a leading zero.
            if (c == CH_ZERO && (base_reg == BASE_DETECT || base_reg == BASE_HEX)) begin
                latched_base = base_reg;
                cur_phase    = PH_ZERO;
                bump_consumed();
                return 1'b0;
            end
            latched_base = (base_reg == BASE_DETECT) ? BASE_DEC : base_reg;
            return digit_or_end(c, r);
        end
        if (cur_phase == PH_ZERO) begin
            if (c == CH_LOWER_X || c == CH_UPPER_X) begin
                latched_base = BASE_HEX;
                cur_phase    = PH_DIGITS;
                bump_consumed();
                return 1'b0;
            end
            if (latched_base == BASE_DETECT) latched_base = BASE_OCT;
            have_digit = 1'b1;
            magnitude  = '0;
            cur_phase  = PH_DIGITS;
        end
        return digit_or_end(c, r);
    endfunction

    function automatic logic [7:0] digit_char(input int d);
        if (d < 10) return CH_ZERO + 8'(d);
        return ($urandom_range(1) ? CH_UPPER_A : CH_LOWER_A) + 8'(d - 10);
    endfunction

    function automatic logic [BASE_BITS-1:0] pick_base();
        int r;
        r = $urandom_range(99);
        if (r < 20) return BASE_DETECT;
        if (r < 30) return BASE_MIN;
        if (r < 40) return BASE_OCT;
        if (r < 55) return BASE_DEC;
        if (r < 70) return BASE_HEX;
        if (r < 80) return BASE_MAX;
        if (r < 90) return BASE_BITS'($urandom_range(2, 36));
        if (r < 95) return 6'd1;
        return BASE_BITS'($urandom_range(37, 63));
    endfunction

    task automatic send_char(input logic [7:0] c, input bit typed = 1'b0,
                             input t_parse_result typed_exp = '0);
        t_parse_result r;
        bit            emit;
        while (!no_idle && $urandom_range(99) < 33) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_char  <= c;
        do @(posedge clk); while (in_stall);
        emit = parse_step(c, r);
        if (typed)
            expected_numbers.push_back(typed_exp);
        else if (emit)
            expected_numbers.push_back(r);
        chars_sent++;
    endtask

    // Stops offering characters until every result has come back and the
    // block has had time to finish any digit still in flight.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_numbers.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_base(input logic [BASE_BITS-1:0] b);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= b;
        @(posedge clk);
        base_reg = b;
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_number(input logic [63:0] mag, input int radix);
        int digs [$];
        do begin
            digs.push_front(int'(mag % radix));
            mag = mag / radix;
        end while (mag != 0);
        foreach (digs[k]) send_char(digit_char(digs[k]));
    endtask

    task automatic send_text();
        int          kind;
        int          radix;
        int          n_dig;
        int          r;
        bit          neg;
        logic [7:0]  t;
        kind = $urandom_range(99);
        // Noise: arbitrary bytes with no structure at all.
        if (kind < 10) begin
            repeat ($urandom_range(1, 8)) send_char(8'($urandom_range(255)));
            return;
        end
        repeat (($urandom_range(3) == 0) ? $urandom_range(1, 4) : 0) send_char(CH_SPACE);
        neg = 1'b0;
        case ($urandom_range(2))
            1: send_char(CH_PLUS);
            2: begin
                neg = 1'b1;
                send_char(CH_MINUS);
            end
            default: ;
        endcase
        if ($urandom_range(99) < 3) set_base(pick_base());
        if (base_reg == BASE_DETECT) begin
            case ($urandom_range(3))
                0: begin send_char(CH_ZERO); send_char(CH_LOWER_X); radix = 16; end
                1: begin send_char(CH_ZERO); send_char(CH_UPPER_X); radix = 16; end
                2: begin send_char(CH_ZERO); radix = 8; end
                default: radix = 10;
            endcase
        end else if (base_reg == BASE_HEX) begin
            case ($urandom_range(3))
                0: begin send_char(CH_ZERO); send_char(CH_LOWER_X); end
                1: begin send_char(CH_ZERO); send_char(CH_UPPER_X); end
                2: send_char(CH_ZERO);
                default: ;
            endcase
            radix = 16;
        end else if (base_reg >= BASE_MIN && base_reg <= BASE_MAX) begin
            radix = int'(base_reg);
        end else begin
            radix = 36;
        end
        if (kind < 20) begin
            // Magnitudes one below, at and one above the signed limit.
            send_number((neg ? SIGN_BIT : POS_LIMIT) - 64'd1 + 64'($urandom_range(2)), radix);
        end else begin
            r = $urandom_range(99);
            if (r < 10)      n_dig = 0;
            else if (r < 65) n_dig = $urandom_range(1, 6);
            else if (r < 88) n_dig = $urandom_range(7, 16);
            else             n_dig = $urandom_range(17, 66);
            for (int k = 0; k < n_dig; k++) begin
                send_char(digit_char($urandom_range(radix - 1)));
                if (k == 0 && $urandom_range(99) < 3) set_base(pick_base());
            end
        end
        t = 8'($urandom_range(255));
        while (digit_code(t) < radix) t = 8'($urandom_range(255));
        send_char(t);
    endtask

    // Receiver side: random stall, plus one long hold-off on request.
    always @(posedge clk) begin
        if (hold_req && !hold_started) begin
            hold_started = 1'b1;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= !no_idle && ($urandom_range(99) < 33);
        end
    end

    always @(posedge clk) begin
        t_parse_result got;
        t_parse_result exp;
        if (rst_n && out_valid && !out_stall) begin
            got = '{out_value, out_end_offset, out_digits_found, out_overflow};
            if (expected_numbers.size() == 0) begin
                if (error_count < 10)
                    $display("unexpected result: value %h offset %0d digits %0b overflow %0b",
                             got.value, got.end_offset, got.digits_found, got.overflow);
                error_count++;
            end else begin
                exp = expected_numbers.pop_front();
                if (got.value !== exp.value || got.end_offset !== exp.end_offset ||
                    got.digits_found !== exp.digits_found || got.overflow !== exp.overflow) begin
                    if (error_count < 10)
                        $display({"mismatch (exp/got): value %h/%h offset %0d/%0d",
                                  " digits %0b/%0b overflow %0b/%0b"},
                                 exp.value, got.value, exp.end_offset, got.end_offset,
                                 exp.digits_found, got.digits_found,
                                 exp.overflow, got.overflow);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int  rand_start;
        int  done_items;
        bit  paused;
        paused   = 1'b0;
        base_reg = BASE_RESET;
        clear_parse_state();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_COUNT; i++) begin
            if (DIRECTED_ROWS[i].wr_base) set_base(DIRECTED_ROWS[i].base);
            send_char(DIRECTED_ROWS[i].ch, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].exp);
        end

        rand_start = chars_sent;
        while (chars_sent - rand_start < RANDOM_ITEMS) begin
            done_items = chars_sent - rand_start;
            no_idle    = (done_items >= 500 && done_items < 800);
            if (done_items >= 1000) hold_req = 1'b1;
            if (done_items >= 1300 && !paused) begin
                paused = 1'b1;
                wait_idle();
            end
            if ($urandom_range(11) == 0) set_base(pick_base());
            send_text();
        end
        no_idle = 1'b0;
        wait_idle();

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
